// ===== hw/rtl/commit_record_parser_top_macros.svh =====
// Assertion macros shared by the commit record parser checker.
`ifndef COMMIT_RECORD_PARSER_TOP_MACROS_SVH
`define COMMIT_RECORD_PARSER_TOP_MACROS_SVH

// Assertion that is ignored while reset is held.
`define CRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define CRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/crp_pkg.sv =====
// Types, codes and constants of the commit record parser.
`default_nettype none

package crp_pkg;

    // Bytes in one parent or catalog hash.
    localparam int unsigned HASH_BYTES = 20;
    // Bytes in the timestamp.
    localparam int unsigned TIME_BYTES = 8;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_MAX_PARENTS      = 1'b1;

    // Configuration reset values.
    localparam logic [7:0] EXPECTED_VERSION_RST = 8'd2;
    localparam logic [7:0] MAX_PARENTS_RST      = 8'd2;

    // Field kind codes.
    typedef enum logic [3:0] {
        KIND_IGNORED   = 4'd0,
        KIND_VERSION   = 4'd1,
        KIND_COUNT     = 4'd2,
        KIND_PARENT    = 4'd3,
        KIND_CATALOG   = 4'd4,
        KIND_TIME      = 4'd5,
        KIND_NAME_LEN  = 4'd6,
        KIND_NAME_STR  = 4'd7,
        KIND_EMAIL_LEN = 4'd8,
        KIND_EMAIL_STR = 4'd9,
        KIND_MSG_LEN   = 4'd10,
        KIND_MSG_STR   = 4'd11,
        KIND_TRAIL     = 4'd12
    } kind_t;

    // Parse status codes.
    typedef enum logic [1:0] {
        STATUS_BUSY    = 2'd0,
        STATUS_OK      = 2'd1,
        STATUS_CORRUPT = 2'd2
    } status_t;

    // Result tdata layout, lowest bit first.
    localparam int unsigned BYTE_LSB   = 0;
    localparam int unsigned PIDX_LSB   = 8;
    localparam int unsigned OFFSET_LSB = 16;
    localparam int unsigned STATUS_LSB = 32;
    localparam int unsigned TIME_LSB   = 34;
    localparam int unsigned M_DATA_W   = 104;

endpackage

`default_nettype wire

// ===== hw/rtl/commit_record_parser_top.sv =====
// Commit record parser: tags every record byte with its field, offset and status.
// Each accepted input request is tagged and its result is registered in the output register.
// Throughput: one byte per cycle; the single output register is refilled in the cycle
// that its result is taken, so the input only stalls while the output is stalled.
// Reset: synchronous, active low; the parser returns to expecting a version byte,
// the output register empties and both configuration registers take their reset values.
`default_nettype none

module commit_record_parser_top
    import crp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration write port.
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_wdata,
    // Input byte stream.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] record_byte
    input  wire logic                s_tlast,   // last_byte
    // Tagged result stream.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [7:0] field_byte, [15:8] parent_index, [31:16] byte_offset,
    // [33:32] parse_status, [97:34] timestamp_value, [103:98] zero
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [3:0]               m_tuser    // [3:0] field_kind
);

    // Parse phases, one-hot.
    typedef enum logic [12:0] {
        PH_VERSION   = 13'h0001,
        PH_COUNT     = 13'h0002,
        PH_PARENT    = 13'h0004,
        PH_CATALOG   = 13'h0008,
        PH_TIME      = 13'h0010,
        PH_NAME_LEN  = 13'h0020,
        PH_NAME_STR  = 13'h0040,
        PH_EMAIL_LEN = 13'h0080,
        PH_EMAIL_STR = 13'h0100,
        PH_MSG_LEN   = 13'h0200,
        PH_MSG_STR   = 13'h0400,
        PH_TRAIL     = 13'h0800,
        PH_BAD       = 13'h1000
    } phase_t;

    logic [7:0]  expected_version_reg;
    logic [7:0]  max_parents_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] counter_reg, counter_next;
    logic [7:0]  parents_reg, parents_next;
    logic [7:0]  parent_num_reg, parent_num_next;
    logic [15:0] str_len_reg, str_len_next;
    logic [63:0] time_reg, time_next;
    logic        corrupt_reg, corrupt_next;

    logic        out_valid_reg;
    kind_t       out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_pidx_reg, out_pidx_next;
    logic [15:0] out_offset_reg, out_offset_next;
    status_t     out_status_reg, out_status_next;
    logic [63:0] out_time_reg;

    logic        accept;
    logic [16:0] counter_inc;
    logic [8:0]  parent_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign counter_inc = {1'b0, counter_reg} + 17'd1;
    assign parent_inc  = {1'b0, parent_num_reg} + 9'd1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_version_reg <= EXPECTED_VERSION_RST;
            max_parents_reg      <= MAX_PARENTS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: expected_version_reg <= cfg_wdata;
                CFG_MAX_PARENTS:      max_parents_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next parse state and the tags of the incoming byte.
    always_comb begin
        phase_t      ph_work;
        logic [15:0] len_full;
        ph_work         = phase_reg;
        counter_next    = counter_reg;
        parents_next    = parents_reg;
        parent_num_next = parent_num_reg;
        str_len_next    = str_len_reg;
        time_next       = time_reg;
        corrupt_next    = corrupt_reg;
        out_kind_next   = KIND_IGNORED;
        out_pidx_next   = 8'd0;
        out_offset_next = 16'd0;
        len_full        = {s_tdata, str_len_reg[7:0]};

        case (phase_reg)
            PH_VERSION: begin
                out_kind_next = KIND_VERSION;
                if (s_tdata != expected_version_reg) begin
                    corrupt_next = 1'b1;
                    ph_work      = PH_BAD;
                end else begin
                    ph_work = PH_COUNT;
                end
            end
            PH_COUNT: begin
                out_kind_next = KIND_COUNT;
                if (s_tdata > max_parents_reg) begin
                    corrupt_next = 1'b1;
                    ph_work      = PH_BAD;
                end else begin
                    parents_next    = s_tdata;
                    parent_num_next = 8'd0;
                    counter_next    = 16'd0;
                    ph_work         = (s_tdata == 8'd0) ? PH_CATALOG : PH_PARENT;
                end
            end
            PH_PARENT: begin
                out_kind_next   = KIND_PARENT;
                out_pidx_next   = parent_num_reg;
                out_offset_next = counter_reg;
                counter_next    = counter_inc[15:0];
                if (counter_inc >= 17'(HASH_BYTES)) begin
                    counter_next    = 16'd0;
                    parent_num_next = parent_inc[7:0];
                    if (parent_inc >= {1'b0, parents_reg}) begin
                        ph_work = PH_CATALOG;
                    end
                end
            end
            PH_CATALOG: begin
                out_kind_next   = KIND_CATALOG;
                out_offset_next = counter_reg;
                counter_next    = counter_inc[15:0];
                if (counter_inc >= 17'(HASH_BYTES)) begin
                    counter_next = 16'd0;
                    ph_work      = PH_TIME;
                end
            end
            PH_TIME: begin
                out_kind_next   = KIND_TIME;
                out_offset_next = counter_reg;
                time_next[{counter_reg[2:0], 3'b000} +: 8] =
                    time_reg[{counter_reg[2:0], 3'b000} +: 8] | s_tdata;
                counter_next = counter_inc[15:0];
                if (counter_inc >= 17'(TIME_BYTES)) begin
                    counter_next = 16'd0;
                    ph_work      = PH_NAME_LEN;
                end
            end
            PH_NAME_LEN, PH_EMAIL_LEN, PH_MSG_LEN: begin
                out_kind_next   = (phase_reg == PH_NAME_LEN)  ? KIND_NAME_LEN :
                                  (phase_reg == PH_EMAIL_LEN) ? KIND_EMAIL_LEN :
                                                                KIND_MSG_LEN;
                out_offset_next = counter_reg;
                if (counter_reg == 16'd0) begin
                    str_len_next = {8'd0, s_tdata};
                    counter_next = 16'd1;
                end else begin
                    str_len_next = len_full;
                    counter_next = 16'd0;
                    // An empty string skips to the next length field, or to the trailer.
                    if (phase_reg == PH_NAME_LEN) begin
                        ph_work = (len_full == 16'd0) ? PH_EMAIL_LEN : PH_NAME_STR;
                    end else if (phase_reg == PH_EMAIL_LEN) begin
                        ph_work = (len_full == 16'd0) ? PH_MSG_LEN : PH_EMAIL_STR;
                    end else begin
                        ph_work = (len_full == 16'd0) ? PH_TRAIL : PH_MSG_STR;
                    end
                end
            end
            PH_NAME_STR, PH_EMAIL_STR, PH_MSG_STR: begin
                out_kind_next   = (phase_reg == PH_NAME_STR)  ? KIND_NAME_STR :
                                  (phase_reg == PH_EMAIL_STR) ? KIND_EMAIL_STR :
                                                                KIND_MSG_STR;
                out_offset_next = counter_reg;
                counter_next    = counter_inc[15:0];
                if (counter_inc >= {1'b0, str_len_reg}) begin
                    counter_next = 16'd0;
                    ph_work      = (phase_reg == PH_NAME_STR)  ? PH_EMAIL_LEN :
                                   (phase_reg == PH_EMAIL_STR) ? PH_MSG_LEN :
                                                                 PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                out_kind_next   = KIND_TRAIL;
                out_offset_next = counter_reg;
                if (counter_reg != 16'hFFFF) begin
                    counter_next = counter_inc[15:0];
                end
            end
            default: begin
                out_kind_next = KIND_IGNORED;
            end
        endcase

        // Status reflects the state after this byte, before any end-of-record clear.
        if (corrupt_next) begin
            out_status_next = STATUS_CORRUPT;
        end else if (ph_work == PH_TRAIL) begin
            out_status_next = STATUS_OK;
        end else if (s_tlast) begin
            out_status_next = STATUS_CORRUPT;
        end else begin
            out_status_next = STATUS_BUSY;
        end

        phase_next = ph_work;

        // The last byte of a record returns the parser to its start.
        if (s_tlast) begin
            phase_next      = PH_VERSION;
            counter_next    = 16'd0;
            parents_next    = 8'd0;
            parent_num_next = 8'd0;
            str_len_next    = 16'd0;
            corrupt_next    = 1'b0;
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_VERSION;
            counter_reg    <= 16'd0;
            parents_reg    <= 8'd0;
            parent_num_reg <= 8'd0;
            str_len_reg    <= 16'd0;
            time_reg       <= 64'd0;
            corrupt_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            counter_reg    <= counter_next;
            parents_reg    <= parents_next;
            parent_num_reg <= parent_num_next;
            str_len_reg    <= str_len_next;
            time_reg       <= s_tlast ? 64'd0 : time_next;
            corrupt_reg    <= corrupt_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= s_tdata;
            out_pidx_reg   <= out_pidx_next;
            out_offset_reg <= out_offset_next;
            out_status_reg <= out_status_next;
            out_time_reg   <= time_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_time_reg, out_status_reg, out_offset_reg,
                       out_pidx_reg, out_byte_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/crp_checker.sv =====
// Port-level checker for the commit record parser, bound to the top level.
`default_nettype none

`include "commit_record_parser_top_macros.svh"

module crp_checker
    import crp_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [3:0]          m_tuser
);

    logic                  stalled;
    logic                  trail_out;
    logic [1:0]            status_bits;
    logic [M_DATA_W+3:0]   m_bus;

    // Shorthands for the result side.
    assign stalled     = m_tvalid && !m_tready;
    assign trail_out   = m_tvalid && (m_tuser == KIND_TRAIL);
    assign status_bits = m_tdata[STATUS_LSB +: 2];
    assign m_bus       = {m_tuser, m_tdata};

    // A stalled result holds its payload.
    `CRP_ASSERT(a_stall_hold, stalled |=> m_tvalid && $stable(m_bus), "stalled result changed")

    // Every accepted request yields a result in the next cycle.
    `CRP_ASSERT(a_accept_result, s_tvalid && s_tready |=> m_tvalid, "request gave no result")

    // With a single output register, a stalled output blocks the input.
    `CRP_ASSERT(a_stall_blocks, stalled |-> !s_tready, "input taken in a stall")

    // Trailing bytes only follow a complete, valid record.
    `CRP_ASSERT(a_trail_ok, trail_out |-> status_bits == STATUS_OK, "trailing byte not valid")

    // Reset empties the output register.
    `CRP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind commit_record_parser_top crp_checker u_crp_checker (.*);

`default_nettype wire

// ===== dv/commit_record_parser_checker.sv =====
// Checker for the commit record parser: predicts every tagged byte and compares the results.
`timescale 1ns / 100ps

module commit_record_parser_checker
    import crp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] record_byte
    input  logic                s_tlast,   // last_byte
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] field_byte, [15:8] parent_index, [31:16] byte_offset,
    // [33:32] parse_status, [97:34] timestamp_value, [103:98] zero
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [3:0]          m_tuser,   // [3:0] field_kind
    output int unsigned         pending,
    output int unsigned         errors
);

    // Where the parser stands within a record.
    typedef enum logic [3:0] {
        P_VER, P_COUNT, P_PARENT, P_CATALOG, P_TIME,
        P_NAME_LEN, P_NAME_TXT, P_EMAIL_LEN, P_EMAIL_TXT,
        P_MSG_LEN, P_MSG_TXT, P_TRAIL, P_DEAD
    } phase_t;

    // One tagged byte as the parser should report it.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  pidx;
        logic [15:0] offset;
        status_t     status;
        logic [63:0] stamp;
    } tag_t;

    // Copy of the configuration registers.
    logic [7:0]  accept_version;
    logic [7:0]  parent_limit;

    // Copy of the parser state.
    phase_t      rec_phase;
    logic [15:0] field_pos;
    logic [7:0]  parents_due;
    logic [7:0]  parent_no;
    logic [15:0] text_len;
    logic [63:0] stamp_acc;
    logic        broken;

    tag_t        tag_q[$];
    int unsigned err_total = 0;

    initial begin
        pending = 0;
        errors  = 0;
    end

    function automatic void clear_record_state();
        rec_phase   = P_VER;
        field_pos   = '0;
        parents_due = '0;
        parent_no   = '0;
        text_len    = '0;
        stamp_acc   = '0;
        broken      = 1'b0;
    endfunction

    // Phase that follows a finished string: the email length, the message length, then trailing bytes.
    function automatic phase_t string_done(input phase_t ph);
        case (ph)
            P_NAME_LEN, P_NAME_TXT:   return P_EMAIL_LEN;
            P_EMAIL_LEN, P_EMAIL_TXT: return P_MSG_LEN;
            default:                  return P_TRAIL;
        endcase
    endfunction

    // Works out the tag of one accepted byte and advances the parser copy.
    task automatic tag_record_byte(input logic [7:0] b, input logic fin, output tag_t t);
        t           = '0;
        t.kind      = KIND_IGNORED;
        t.data_byte = b;
        case (rec_phase)
            P_VER: begin
                t.kind = KIND_VERSION;
                if (b != accept_version) begin
                    broken    = 1'b1;
                    rec_phase = P_DEAD;
                end else begin
                    rec_phase = P_COUNT;
                end
            end
            P_COUNT: begin
                t.kind = KIND_COUNT;
                if (b > parent_limit) begin
                    broken    = 1'b1;
                    rec_phase = P_DEAD;
                end else begin
                    parents_due = b;
                    parent_no   = '0;
                    field_pos   = '0;
                    rec_phase   = (b == 8'd0) ? P_CATALOG : P_PARENT;
                end
            end
            P_PARENT: begin
                t.kind    = KIND_PARENT;
                t.pidx    = parent_no;
                t.offset  = field_pos;
                field_pos = field_pos + 16'd1;
                if (field_pos >= HASH_BYTES) begin
                    field_pos = '0;
                    parent_no = parent_no + 8'd1;
                    if (parent_no >= parents_due) rec_phase = P_CATALOG;
                end
            end
            P_CATALOG: begin
                t.kind    = KIND_CATALOG;
                t.offset  = field_pos;
                field_pos = field_pos + 16'd1;
                if (field_pos >= HASH_BYTES) begin
                    field_pos = '0;
                    rec_phase = P_TIME;
                end
            end
            P_TIME: begin
                t.kind    = KIND_TIME;
                t.offset  = field_pos;
                stamp_acc = stamp_acc | ({56'd0, b} << (8 * field_pos[2:0]));
                field_pos = field_pos + 16'd1;
                if (field_pos >= TIME_BYTES) begin
                    field_pos = '0;
                    rec_phase = P_NAME_LEN;
                end
            end
            P_NAME_LEN, P_EMAIL_LEN, P_MSG_LEN: begin
                t.kind   = (rec_phase == P_NAME_LEN)  ? KIND_NAME_LEN :
                           (rec_phase == P_EMAIL_LEN) ? KIND_EMAIL_LEN : KIND_MSG_LEN;
                t.offset = field_pos;
                if (field_pos == 16'd0) begin
                    text_len  = {8'd0, b};
                    field_pos = 16'd1;
                end else begin
                    text_len[15:8] = b;
                    field_pos      = '0;
                    // An empty string skips to the next length field, or to the trailer.
                    if (text_len == 16'd0) rec_phase = string_done(rec_phase);
                    else rec_phase = (rec_phase == P_NAME_LEN)  ? P_NAME_TXT :
                                     (rec_phase == P_EMAIL_LEN) ? P_EMAIL_TXT : P_MSG_TXT;
                end
            end
            P_NAME_TXT, P_EMAIL_TXT, P_MSG_TXT: begin
                t.kind    = (rec_phase == P_NAME_TXT)  ? KIND_NAME_STR :
                            (rec_phase == P_EMAIL_TXT) ? KIND_EMAIL_STR : KIND_MSG_STR;
                t.offset  = field_pos;
                field_pos = field_pos + 16'd1;
                if (field_pos >= text_len) begin
                    field_pos = '0;
                    rec_phase = string_done(rec_phase);
                end
            end
            P_TRAIL: begin
                // Trailing offsets stop counting at the top of the range.
                t.kind   = KIND_TRAIL;
                t.offset = field_pos;
                if (field_pos != 16'hFFFF) field_pos = field_pos + 16'd1;
            end
            default: begin
            end
        endcase

        // Corruption wins, then completion; a last byte before completion is an early end.
        if (broken) t.status = STATUS_CORRUPT;
        else if (rec_phase == P_TRAIL) t.status = STATUS_OK;
        else if (fin) t.status = STATUS_CORRUPT;
        else t.status = STATUS_BUSY;
        t.stamp = stamp_acc;

        if (fin) clear_record_state();
    endtask

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        err_total++;
    endtask

    // Result requests are checked before the input request of the same edge is predicted.
    always @(posedge aclk) begin : monitor
        tag_t want;
        tag_t fresh;
        if (!aresetn) begin
            accept_version = EXPECTED_VERSION_RST;
            parent_limit   = MAX_PARENTS_RST;
            clear_record_state();
            tag_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (tag_q.size() == 0) begin
                    $display("%0t: result with no request waiting, kind %0d, byte %0h",
                             $time, m_tuser, m_tdata[BYTE_LSB +: 8]);
                    err_total++;
                end else begin
                    want = tag_q.pop_front();
                    if (m_tuser !== want.kind)
                        report("field kind", want.kind, m_tuser);
                    if (m_tdata[BYTE_LSB +: 8] !== want.data_byte)
                        report("field byte", want.data_byte, m_tdata[BYTE_LSB +: 8]);
                    if (m_tdata[PIDX_LSB +: 8] !== want.pidx)
                        report("parent index", want.pidx, m_tdata[PIDX_LSB +: 8]);
                    if (m_tdata[OFFSET_LSB +: 16] !== want.offset)
                        report("byte offset", want.offset, m_tdata[OFFSET_LSB +: 16]);
                    if (m_tdata[STATUS_LSB +: 2] !== want.status)
                        report("parse status", want.status, m_tdata[STATUS_LSB +: 2]);
                    if (m_tdata[TIME_LSB +: 64] !== want.stamp)
                        report("timestamp", want.stamp, m_tdata[TIME_LSB +: 64]);
                end
            end
            if (s_tvalid && s_tready) begin
                tag_record_byte(s_tdata, s_tlast, fresh);
                tag_q.push_back(fresh);
            end
            if (cfg_we) begin
                if (cfg_index == CFG_EXPECTED_VERSION) accept_version = cfg_wdata;
                else parent_limit = cfg_wdata;
            end
        end
        pending <= tag_q.size();
        errors  <= err_total;
    end

endmodule

// ===== dv/commit_record_parser_top_test.sv =====
// Testbench top for the commit record parser: clock, reset, record stimulus and verdict.
`timescale 1ns / 100ps

module commit_record_parser_top_test;
    import crp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned PHASE_BYTES  = 15;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned NO_CAP       = 32'hFFFF_FFFF;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_EXPECTED_VERSION;
    logic [7:0]          cfg_wdata = 8'd0;
    logic                s_tvalid  = 1'b0;
    logic [7:0]          s_tdata   = 8'd0;
    logic                s_tlast   = 1'b0;
    logic                m_tready  = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic [3:0]          m_tuser;
    int unsigned         pending;
    int unsigned         errors;

    // Stimulus state shared by the tasks below.
    logic [7:0]  rec_q[$];
    int unsigned rec_cap;
    logic [7:0]  want_ver    = EXPECTED_VERSION_RST;
    logic [7:0]  par_cap     = MAX_PARENTS_RST;
    int unsigned tx_idle_pct = 20;
    int unsigned rx_idle_pct = 20;
    bit          rx_hold_go  = 1'b0;
    int unsigned bytes_sent  = 0;

    commit_record_parser_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    commit_record_parser_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .pending   (pending),
        .errors    (errors)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Run limit.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Idle gaps are mostly short, now and then long.
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [15:0] pick_text_len(input bit wide);
        if (wide && $urandom_range(0, 1) == 1) return 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) return 16'd0;
        return 16'($urandom_range(1, 6));
    endfunction

    // Result side: random stalls, or one long hold when the stimulus asks for it.
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (rx_hold_go) begin
                rx_hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one byte and waits for its request to be taken; may idle afterwards.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] ver, input logic [7:0] cap);
        wait_drained();
        cfg_write(CFG_EXPECTED_VERSION, ver);
        cfg_write(CFG_MAX_PARENTS, cap);
        want_ver = ver;
        par_cap  = cap;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        if (rec_q.size() < rec_cap) rec_q.push_back(b);
    endfunction

    function automatic void put_text(input logic [15:0] len);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
    endfunction

    // Builds a record with random hashes, timestamp and text, cut after cap bytes.
    task automatic send_record(input logic [7:0] ver, input logic [7:0] cnt,
                               input logic [15:0] len_name, input logic [15:0] len_mail,
                               input logic [15:0] len_msg, input int unsigned trail,
                               input int unsigned cap);
        rec_q.delete();
        rec_cap = cap;
        put_byte(ver);
        put_byte(cnt);
        repeat (cnt * HASH_BYTES + HASH_BYTES + TIME_BYTES)
            put_byte(8'($urandom_range(0, 255)));
        put_text(len_name);
        put_text(len_mail);
        put_text(len_msg);
        repeat (trail) put_byte(8'($urandom_range(0, 255)));
        foreach (rec_q[i]) push_byte(rec_q[i], i == rec_q.size() - 1);
    endtask

    // Mostly well-formed records, then cut ones, bad headers and plain noise.
    task automatic random_record();
        int unsigned mode;
        int unsigned npar;
        mode = $urandom_range(0, 99);
        npar = $urandom_range(0, (par_cap < 3) ? par_cap : 3);
        if (mode < 65) begin
            send_record(want_ver, 8'(npar), pick_text_len(1'b0), pick_text_len(1'b0),
                        pick_text_len(1'b0), $urandom_range(0, 3), NO_CAP);
        end else if (mode < 85) begin
            send_record(want_ver, 8'(npar), pick_text_len(1'b1), pick_text_len(1'b1),
                        pick_text_len(1'b1), 0, $urandom_range(1, 80));
        end else if (mode < 93 && par_cap != 8'hFF) begin
            send_record(want_ver, 8'($urandom_range(par_cap + 1, 255)), 16'd0, 16'd0,
                        16'd0, 0, $urandom_range(2, 8));
        end else begin
            send_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'd0, 16'd0, 16'd0, 0, $urandom_range(1, 12));
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short header cases under the reset configuration.
        send_record(8'h00, 8'd0, 16'd0, 16'd0, 16'd0, 0, 1);    // wrong version, alone
        send_record(want_ver, 8'd0, 16'd0, 16'd0, 16'd0, 0, 1); // ends on the version byte
        send_record(8'hFF, 8'd2, 16'd0, 16'd0, 16'd0, 0, 4);    // wrong version, rest ignored
        send_record(want_ver, 8'd3, 16'd0, 16'd0, 16'd0, 0, 4); // too many parents
        send_record(want_ver, 8'd0, 16'd0, 16'd0, 16'd0, 0, 6); // ends inside the catalog hash
        send_record(want_ver, 8'd2, 16'd0, 16'd0, 16'd0, 0, 8); // ends inside a parent hash

        // Whole records and cuts in length and text.
        send_record(want_ver, 8'd1, 16'd2, 16'd0, 16'd1, 1, NO_CAP);
        send_record(want_ver, 8'd0, 16'd4, 16'd0, 16'd0, 0, 31);     // ends between length bytes
        send_record(want_ver, 8'd0, 16'hFFFF, 16'd0, 16'd0, 0, 36);  // ends inside the name

        // Lowest register values.
        set_config(8'd0, 8'd0);
        send_record(8'd0, 8'd0, 16'd1, 16'd0, 16'd2, 1, NO_CAP);
        send_record(8'd0, 8'd1, 16'd0, 16'd0, 16'd0, 0, 5);
        send_record(8'd1, 8'd0, 16'd0, 16'd0, 16'd0, 0, 3);

        // Highest register values: the largest parent count is accepted.
        set_config(8'hFF, 8'hFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_record(8'hFF, 8'hFF, 16'd0, 16'd0, 16'd0, 0, 12);
        send_record(8'hFF, 8'd0, 16'd0, 16'd0, 16'd1, 3, NO_CAP);

        // Random configurations with random records.
        for (int ph = 0; ph < 4; ph++) begin
            set_config(($urandom_range(0, 1) == 1) ? 8'd2 : 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(0, 255)));
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                tx_idle_pct = pick_idle();
                rx_idle_pct = pick_idle();
                if (ph == 0 && bytes_sent + PHASE_BYTES == target) begin
                    // Long receiver hold while the sender keeps offering.
                    tx_idle_pct = 0;
                    rx_hold_go  = 1'b1;
                    send_record(want_ver, 8'd0, 16'd1, 16'd1, 16'd1, 1, NO_CAP);
                end else if (ph == 2 && $urandom_range(0, 3) == 0) begin
                    wait_drained();
                    random_record();
                end else begin
                    random_record();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
